>>> src/tcwc_pkg.sv
// package for the two-register word cpu
// holds action, opcode, stop cause and configuration index codes, field widths
// and the control struct between the sequencer and the top level; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package tcwc_pkg;

   localparam int FIELD_W   = 32;
   localparam int ADDR_IN_W = 10;
   localparam int OFF_W     = 10;
   localparam int PLEN_W    = 11;
   localparam int CSR_IDX_W = 1;

   localparam logic [OFF_W-1:0]  DATA_OFFSET_RST    = 10'd512;
   localparam logic [PLEN_W-1:0] PROGRAM_LENGTH_RST = 11'd1024;

   localparam logic [CSR_IDX_W-1:0] CSR_DATA_OFFSET    = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_PROGRAM_LENGTH = 1'b1;

   typedef enum logic [1:0] {
      ACT_WRITE   = 2'd0,
      ACT_EXEC    = 2'd1,
      ACT_RESTART = 2'd2,
      ACT_READ    = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      CAUSE_NONE  = 2'd0,
      CAUSE_HALT  = 2'd1,
      CAUSE_RANGE = 2'd2
   } cause_type;

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_OP    = 5'b00100,
      ST_IMM   = 5'b01000,
      ST_DATA  = 5'b10000
   } state_type;

   localparam logic [4:0] OP_HALT  = 5'd0;
   localparam logic [4:0] OP_JUMP  = 5'd1;
   localparam logic [4:0] OP_MOVXI = 5'd2;
   localparam logic [4:0] OP_MOVYI = 5'd3;
   localparam logic [4:0] OP_STX   = 5'd4;
   localparam logic [4:0] OP_STY   = 5'd5;
   localparam logic [4:0] OP_LDX   = 5'd6;
   localparam logic [4:0] OP_LDY   = 5'd7;
   localparam logic [4:0] OP_ADDXY = 5'd8;
   localparam logic [4:0] OP_ADDYX = 5'd9;
   localparam logic [4:0] OP_ADDXI = 5'd10;
   localparam logic [4:0] OP_ADDYI = 5'd11;
   localparam logic [4:0] OP_INCX  = 5'd12;
   localparam logic [4:0] OP_INCY  = 5'd13;
   localparam logic [4:0] OP_DECX  = 5'd14;
   localparam logic [4:0] OP_DECY  = 5'd15;
   localparam logic [4:0] OP_JZX   = 5'd16;
   localparam logic [4:0] OP_JZY   = 5'd17;
   localparam logic [4:0] OP_LDYX  = 5'd18;
   localparam logic [4:0] OP_STYX  = 5'd19;

   typedef struct packed {
      logic busy;
      logic fin;
      logic fin_rd;
   } stat_type;

endpackage

`default_nettype wire

>>> src/tcwc_mem.sv
// main word memory: one write port, one read port, registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module tcwc_mem #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

endmodule

`default_nettype wire

>>> src/tcwc_core.sv
// instruction sequencer: architectural registers, memory clearing pass and
// opcode/operand/data fetch through the shared memory port; uses tcwc_pkg
`timescale 1ns / 1ps
`default_nettype none

module tcwc_core #(
   parameter int MEM_WORDS = 1024,
   parameter int WORD_BITS = 32
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 acc,
   input  wire logic [1:0]                           action,
   input  wire logic [tcwc_pkg::ADDR_IN_W-1:0]       addr,
   input  wire logic [WORD_BITS-1:0]                 data,
   input  wire logic [tcwc_pkg::OFF_W-1:0]           data_offset,
   input  wire logic [tcwc_pkg::PLEN_W-1:0]          program_length,
   output tcwc_pkg::stat_type                        stat,
   output logic signed [WORD_BITS-1:0]               ip_ff,
   output logic signed [WORD_BITS-1:0]               x_ff,
   output logic signed [WORD_BITS-1:0]               y_ff,
   output logic                                      halt_ff,
   output tcwc_pkg::cause_type                       cause_ff,
   output logic                                      mem_we,
   output logic [$clog2(MEM_WORDS)-1:0]              mem_waddr,
   output logic [WORD_BITS-1:0]                      mem_wdata,
   output logic                                      mem_re,
   output logic [$clog2(MEM_WORDS)-1:0]              mem_raddr,
   input  wire logic [WORD_BITS-1:0]                 mem_rdata
);

   import tcwc_pkg::*;

   localparam int AddrW = $clog2(MEM_WORDS);
   localparam int CmpW  = (WORD_BITS > PLEN_W) ? WORD_BITS : PLEN_W;
   localparam logic signed [WORD_BITS-1:0] One = WORD_BITS'(1);
   localparam logic signed [WORD_BITS-1:0] Two = WORD_BITS'(2);

   function automatic logic out_of_range(input logic signed [WORD_BITS-1:0] p,
                                         input logic [PLEN_W-1:0] len);
      logic [CmpW-1:0] pa;
      logic [CmpW-1:0] la;
      pa = CmpW'($unsigned(p));
      la = CmpW'(len);
      return p[WORD_BITS-1] || (pa >= la);
   endfunction

   function automatic logic [AddrW-1:0] data_addr(input logic signed [WORD_BITS-1:0] w,
                                                  input logic [OFF_W-1:0] off);
      return AddrW'(AddrW'(w) + AddrW'(off));
   endfunction

   state_type                    state_ff, state_in;
   logic [AddrW-1:0]             clr_ff, clr_in;
   logic signed [WORD_BITS-1:0]  ip_in, x_in, y_in;
   logic                         halt_in;
   cause_type                    cause_in;
   logic [4:0]                   op_ff, op_in;
   logic                         opbad_ff, opbad_in;
   logic signed [WORD_BITS-1:0]  nx1_ff, nx1_in, nx2_ff, nx2_in;
   logic                         nx1_oor_ff, nx1_oor_in, nx2_oor_ff, nx2_oor_in;
   logic signed [WORD_BITS-1:0]  imm;
   logic                         imm_oor;
   logic signed [WORD_BITS-1:0]  add_a, add_b, add_sum;
   logic                         add_to_y;
   logic                         chk;
   logic                         done_now;
   action_type                   act;

   assign act     = action_type'(action);
   assign imm     = $signed(mem_rdata);
   assign imm_oor = out_of_range(imm, program_length);
   assign add_sum = add_a + add_b;

   // shared adder for the register arithmetic
   always_comb begin
      add_to_y = 1'b0;
      add_b    = One;
      case (op_ff)
         OP_ADDXY: begin add_b = y_ff; end
         OP_ADDYX: begin add_b = x_ff; add_to_y = 1'b1; end
         OP_ADDXI: begin add_b = imm; end
         OP_ADDYI: begin add_b = imm; add_to_y = 1'b1; end
         OP_INCX:  begin add_b = One; end
         OP_INCY:  begin add_b = One; add_to_y = 1'b1; end
         OP_DECX:  begin add_b = -One; end
         OP_DECY:  begin add_b = -One; add_to_y = 1'b1; end
         default:  begin add_b = One; end
      endcase
      add_a = add_to_y ? y_ff : x_ff;
   end

   always_comb begin
      state_in   = state_ff;
      clr_in     = clr_ff;
      ip_in      = ip_ff;
      x_in       = x_ff;
      y_in       = y_ff;
      halt_in    = halt_ff;
      cause_in   = cause_ff;
      op_in      = op_ff;
      opbad_in   = opbad_ff;
      nx1_in     = nx1_ff;
      nx2_in     = nx2_ff;
      nx1_oor_in = nx1_oor_ff;
      nx2_oor_in = nx2_oor_ff;
      mem_we     = 1'b0;
      mem_waddr  = clr_ff;
      mem_wdata  = '0;
      mem_re     = 1'b0;
      mem_raddr  = AddrW'(ip_ff);
      stat       = '0;
      chk        = 1'b0;
      done_now   = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            stat.busy = 1'b1;
            mem_we    = 1'b1;
            clr_in    = AddrW'(clr_ff + 1'b1);
            if (clr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (acc) begin
               case (act)
                  ACT_WRITE: begin
                     mem_we     = 1'b1;
                     mem_waddr  = AddrW'(addr);
                     mem_wdata  = data;
                     stat.fin   = 1'b1;
                  end
                  ACT_READ: begin
                     mem_re      = 1'b1;
                     mem_raddr   = AddrW'(addr);
                     stat.fin    = 1'b1;
                     stat.fin_rd = 1'b1;
                  end
                  ACT_RESTART: begin
                     ip_in    = '0;
                     x_in     = '0;
                     y_in     = '0;
                     halt_in  = 1'b0;
                     cause_in = CAUSE_NONE;
                     stat.fin = 1'b1;
                  end
                  ACT_EXEC: begin
                     if (halt_ff) begin
                        stat.fin = 1'b1;
                     end else if (out_of_range(ip_ff, program_length)) begin
                        halt_in  = 1'b1;
                        cause_in = CAUSE_RANGE;
                        stat.fin = 1'b1;
                     end else begin
                        mem_re    = 1'b1;
                        mem_raddr = AddrW'(ip_ff);
                        state_in  = ST_OP;
                     end
                  end
                  default: begin
                     stat.fin = 1'b1;
                  end
               endcase
            end
         end
         ST_OP: begin
            stat.busy  = 1'b1;
            op_in      = mem_rdata[4:0];
            opbad_in   = |mem_rdata[WORD_BITS-1:5];
            nx1_in     = ip_ff + One;
            nx2_in     = ip_ff + Two;
            nx1_oor_in = out_of_range(ip_ff + One, program_length);
            nx2_oor_in = out_of_range(ip_ff + Two, program_length);
            mem_re     = 1'b1;
            mem_raddr  = AddrW'(AddrW'(ip_ff) + AddrW'(1));
            state_in   = ST_IMM;
         end
         ST_IMM: begin
            stat.busy = 1'b1;
            done_now  = 1'b1;
            if (opbad_ff) begin
               ip_in = nx1_ff;
               chk   = nx1_oor_ff;
            end else begin
               case (op_ff)
                  OP_HALT: begin
                     halt_in  = 1'b1;
                     cause_in = CAUSE_HALT;
                  end
                  OP_JUMP: begin
                     ip_in = imm;
                     chk   = imm_oor;
                  end
                  OP_MOVXI: begin
                     x_in  = imm;
                     ip_in = nx2_ff;
                     chk   = nx2_oor_ff;
                  end
                  OP_MOVYI: begin
                     y_in  = imm;
                     ip_in = nx2_ff;
                     chk   = nx2_oor_ff;
                  end
                  OP_STX, OP_STY: begin
                     mem_we    = 1'b1;
                     mem_waddr = data_addr(imm, data_offset);
                     mem_wdata = (op_ff == OP_STX) ? x_ff : y_ff;
                     ip_in     = nx2_ff;
                     chk       = nx2_oor_ff;
                  end
                  OP_LDX, OP_LDY: begin
                     mem_re    = 1'b1;
                     mem_raddr = data_addr(imm, data_offset);
                     done_now  = 1'b0;
                     state_in  = ST_DATA;
                  end
                  OP_LDYX: begin
                     mem_re    = 1'b1;
                     mem_raddr = data_addr(x_ff, data_offset);
                     done_now  = 1'b0;
                     state_in  = ST_DATA;
                  end
                  OP_STYX: begin
                     mem_we    = 1'b1;
                     mem_waddr = data_addr(x_ff, data_offset);
                     mem_wdata = y_ff;
                     ip_in     = nx1_ff;
                     chk       = nx1_oor_ff;
                  end
                  OP_ADDXY, OP_ADDYX, OP_INCX, OP_INCY, OP_DECX, OP_DECY: begin
                     if (add_to_y) begin
                        y_in = add_sum;
                     end else begin
                        x_in = add_sum;
                     end
                     ip_in = nx1_ff;
                     chk   = nx1_oor_ff;
                  end
                  OP_ADDXI, OP_ADDYI: begin
                     if (add_to_y) begin
                        y_in = add_sum;
                     end else begin
                        x_in = add_sum;
                     end
                     ip_in = nx2_ff;
                     chk   = nx2_oor_ff;
                  end
                  OP_JZX: begin
                     ip_in = (x_ff == '0) ? imm : nx2_ff;
                     chk   = (x_ff == '0) ? imm_oor : nx2_oor_ff;
                  end
                  OP_JZY: begin
                     ip_in = (y_ff == '0) ? imm : nx2_ff;
                     chk   = (y_ff == '0) ? imm_oor : nx2_oor_ff;
                  end
                  default: begin
                     ip_in = nx1_ff;
                     chk   = nx1_oor_ff;
                  end
               endcase
            end
         end
         ST_DATA: begin
            stat.busy = 1'b1;
            done_now  = 1'b1;
            case (op_ff)
               OP_LDX: begin
                  x_in  = $signed(mem_rdata);
                  ip_in = nx2_ff;
                  chk   = nx2_oor_ff;
               end
               OP_LDY: begin
                  y_in  = $signed(mem_rdata);
                  ip_in = nx2_ff;
                  chk   = nx2_oor_ff;
               end
               default: begin
                  y_in  = $signed(mem_rdata);
                  ip_in = nx1_ff;
                  chk   = nx1_oor_ff;
               end
            endcase
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      // finish: post-instruction range check
      if (done_now) begin
         stat.fin = 1'b1;
         state_in = ST_IDLE;
         if (chk) begin
            halt_in  = 1'b1;
            cause_in = CAUSE_RANGE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         ip_ff    <= '0;
         x_ff     <= '0;
         y_ff     <= '0;
         halt_ff  <= 1'b0;
         cause_ff <= CAUSE_NONE;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         ip_ff    <= ip_in;
         x_ff     <= x_in;
         y_ff     <= y_in;
         halt_ff  <= halt_in;
         cause_ff <= cause_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      opbad_ff   <= opbad_in;
      nx1_ff     <= nx1_in;
      nx2_ff     <= nx2_in;
      nx1_oor_ff <= nx1_oor_in;
      nx2_oor_ff <= nx2_oor_in;
   end

   a_halt_cause: assert property (@(posedge clock) disable iff (reset)
      halt_ff == (cause_ff != CAUSE_NONE))
      else $error("halt flag and stop cause disagree");

   a_data_after_imm: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DATA |-> $past(state_ff) == ST_IMM)
      else $error("data fetch not preceded by operand fetch");

   a_one_mem_access: assert property (@(posedge clock) disable iff (reset)
      !(mem_we && mem_re))
      else $error("memory read and write issued together");

   a_fin_ends_exec: assert property (@(posedge clock) disable iff (reset)
      stat.fin && (state_ff != ST_IDLE) |=> state_ff == ST_IDLE)
      else $error("sequencer did not return to idle after finishing");

endmodule

`default_nettype wire

>>> src/two_register_word_cpu.sv
// results: a write, read or restart item passes the finish stage register and then the output
// register; an execute item first passes the opcode, operand and (for loads) data fetch states
// throughput: one write/read/restart item per cycle while rsp_stall does not hold the output;
// an execute item keeps req_stall high until it finishes, set by the single read port that
// fetches opcode, operand and data in turn; reset: a clearing pass zeroes the memory with
// req_stall high; configuration writes are taken during it
`timescale 1ns / 1ps
`default_nettype none

module two_register_word_cpu #(
   parameter int MEM_WORDS = 1024,
   parameter int WORD_BITS = 32
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic [1:0]                           req_action,
   input  wire logic [tcwc_pkg::ADDR_IN_W-1:0]       req_address,
   input  wire logic signed [tcwc_pkg::FIELD_W-1:0]  req_data,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic signed [tcwc_pkg::FIELD_W-1:0]       rsp_ip,
   output logic signed [tcwc_pkg::FIELD_W-1:0]       rsp_x_value,
   output logic signed [tcwc_pkg::FIELD_W-1:0]       rsp_y_value,
   output logic                                      rsp_halted,
   output logic [1:0]                                rsp_stop_cause,
   output logic signed [tcwc_pkg::FIELD_W-1:0]       rsp_read_data,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [tcwc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [tcwc_pkg::PLEN_W-1:0]          csr_wdata
);

   import tcwc_pkg::*;

   localparam int AddrW = $clog2(MEM_WORDS);

   stat_type                    stat;
   logic                        accept;
   logic [OFF_W-1:0]            off_ff, off_in;
   logic [PLEN_W-1:0]           plen_ff, plen_in;
   logic                        f_vld_ff, f_vld_in, f_rd_ff, f_rd_in, f_move;
   logic                        o_vld_ff, o_vld_in;
   logic signed [WORD_BITS-1:0] ip_w, x_w, y_w;
   logic                        halt_w;
   cause_type                   cause_w;
   logic                        mem_we, mem_re;
   logic [AddrW-1:0]            mem_waddr, mem_raddr;
   logic [WORD_BITS-1:0]        mem_wdata, mem_rdata;
   logic signed [WORD_BITS-1:0] data_w;
   logic signed [FIELD_W-1:0]   o_ip_ff, o_x_ff, o_y_ff, o_rd_ff;
   logic                        o_halt_ff;
   logic [1:0]                  o_cause_ff;

   assign data_w    = WORD_BITS'(req_data);
   assign csr_ready = 1'b1;
   assign f_move    = f_vld_ff && (!o_vld_ff || !rsp_stall);
   assign req_stall = stat.busy || (f_vld_ff && !f_move);
   assign accept    = req_valid && !req_stall;

   tcwc_core #(
      .MEM_WORDS(MEM_WORDS),
      .WORD_BITS(WORD_BITS)
   ) u_core (
      .clock          (clock),
      .reset          (reset),
      .acc            (accept),
      .action         (req_action),
      .addr           (req_address),
      .data           (data_w),
      .data_offset    (off_ff),
      .program_length (plen_ff),
      .stat           (stat),
      .ip_ff          (ip_w),
      .x_ff           (x_w),
      .y_ff           (y_w),
      .halt_ff        (halt_w),
      .cause_ff       (cause_w),
      .mem_we         (mem_we),
      .mem_waddr      (mem_waddr),
      .mem_wdata      (mem_wdata),
      .mem_re         (mem_re),
      .mem_raddr      (mem_raddr),
      .mem_rdata      (mem_rdata)
   );

   tcwc_mem #(
      .DEPTH(MEM_WORDS),
      .WIDTH(WORD_BITS)
   ) u_mem (
      .clock    (clock),
      .we       (mem_we),
      .waddr    (mem_waddr),
      .wdata    (mem_wdata),
      .re       (mem_re),
      .raddr    (mem_raddr),
      .rdata_ff (mem_rdata)
   );

   always_comb begin
      off_in  = off_ff;
      plen_in = plen_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_DATA_OFFSET:    begin off_in = csr_wdata[OFF_W-1:0]; end
            CSR_PROGRAM_LENGTH: begin plen_in = csr_wdata; end
            default:            begin off_in = off_ff; end
         endcase
      end
   end

   // finish stage then output register; architectural state holds while an item waits
   always_comb begin
      f_vld_in = f_vld_ff;
      f_rd_in  = f_rd_ff;
      if (stat.fin) begin
         f_vld_in = 1'b1;
         f_rd_in  = stat.fin_rd;
      end else if (f_move) begin
         f_vld_in = 1'b0;
      end
      o_vld_in = o_vld_ff && rsp_stall;
      if (f_move) begin
         o_vld_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         off_ff   <= DATA_OFFSET_RST;
         plen_ff  <= PROGRAM_LENGTH_RST;
         f_vld_ff <= 1'b0;
         o_vld_ff <= 1'b0;
      end else begin
         off_ff   <= off_in;
         plen_ff  <= plen_in;
         f_vld_ff <= f_vld_in;
         o_vld_ff <= o_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      f_rd_ff <= f_rd_in;
      if (f_move) begin
         o_ip_ff    <= FIELD_W'(ip_w);
         o_x_ff     <= FIELD_W'(x_w);
         o_y_ff     <= FIELD_W'(y_w);
         o_halt_ff  <= halt_w;
         o_cause_ff <= cause_w;
         o_rd_ff    <= f_rd_ff ? FIELD_W'($signed(mem_rdata)) : '0;
      end
   end

   assign rsp_valid      = o_vld_ff;
   assign rsp_ip         = o_ip_ff;
   assign rsp_x_value    = o_x_ff;
   assign rsp_y_value    = o_y_ff;
   assign rsp_halted     = o_halt_ff;
   assign rsp_stop_cause = o_cause_ff;
   assign rsp_read_data  = o_rd_ff;

   a_busy_no_pending: assert property (@(posedge clock) disable iff (reset)
      stat.busy |-> !f_vld_ff)
      else $error("finish stage holds an item while the sequencer is busy");

   a_fin_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      stat.fin |-> (!f_vld_ff || f_move))
      else $error("finish stage overwritten");

   a_move_shows: assert property (@(posedge clock) disable iff (reset)
      f_move |=> rsp_valid)
      else $error("item moved but no result presented");

endmodule

`default_nettype wire
